### src/assert_macros.svh
// Assertion helpers used by qsvge_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, inactive while reset is asserted
`define QSV_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("qsvge assertion failed");

// Next-cycle implication, inactive while reset is asserted
`define QSV_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("qsvge assertion failed");

`endif

### src/qsvge_pkg.sv
package qsvge_pkg;

  // Command codes carried in the request opcode
  typedef enum logic [2:0] {
    OP_WRITE      = 3'd0,
    OP_READ       = 3'd1,
    OP_INIT       = 3'd2,
    OP_GATE       = 3'd3,
    OP_LANE_RESET = 3'd4,
    OP_COLLAPSE   = 3'd5,
    OP_PROB       = 3'd6
  } op_e;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_QUBITS    = 3'd0,
    CFG_TARGET    = 3'd1,
    CFG_CTRL_MASK = 3'd2,
    CFG_M00       = 3'd3,
    CFG_M01       = 3'd4,
    CFG_M10       = 3'd5,
    CFG_M11       = 3'd6,
    CFG_NORM      = 3'd7
  } cfg_idx_e;

  localparam int unsigned FIELD_ADDR_W = 10;
  localparam logic [31:0] ONE_AMP      = 32'h4000_0000;
  localparam logic [3:0]  GATE_LAST_K  = 4'd15;
  localparam logic [3:0]  PAIR_LAST_K  = 4'd1;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [9:0]         address;
    logic signed [15:0] write_real;
    logic signed [15:0] write_imag;
    logic               measured_value;
  } in_req_t;

  typedef struct packed {
    logic signed [15:0] read_real;
    logic signed [15:0] read_imag;
    logic [31:0]        probability;
    logic               saturated;
  } out_rsp_t;

  typedef struct packed {
    logic [3:0]  qubits_in_use;
    logic [3:0]  target_lane;
    logic [9:0]  control_mask;
    logic [31:0] matrix_00;
    logic [31:0] matrix_01;
    logic [31:0] matrix_10;
    logic [31:0] matrix_11;
    logic [15:0] collapse_norm;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    qubits_in_use: 4'd10,
    target_lane:   4'd0,
    control_mask:  10'd0,
    matrix_00:     32'h4000_0000,
    matrix_01:     32'h0,
    matrix_10:     32'h0,
    matrix_11:     32'h4000_0000,
    collapse_norm: 16'd4096
  };

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_ACCESS, ST_CAP_RD, ST_RD_I, ST_RD_J, ST_CAP,
    ST_MAC, ST_DRAIN, ST_WR_I, ST_WR_J, ST_NEXT, ST_DONE
  } state_e;

  // Source of memory write data
  typedef enum logic [1:0] {
    WS_REQ, WS_CLEAR, WS_PAIR_I, WS_PAIR_J
  } wsel_e;

  typedef struct packed {
    op_e        op;
    logic       load;
    logic       mem_we;
    logic       mem_re;
    wsel_e      wsel;
    logic       cap_a0;
    logic       cap_a1;
    logic       cap_rd;
    logic       mac_issue;
    logic [3:0] mac_k;
    logic       load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

### src/qsvge_dp.sv
module qsvge_dp import qsvge_pkg::*; #(
  parameter int unsigned MAX_QUBITS = 10
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cfg_t                  cfg_i,
  input  in_req_t               in_req_i,
  input  dp_cmd_t               cmd_i,
  input  logic [MAX_QUBITS-1:0] mem_addr_i,
  output dp_status_t            status_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_rsp_t              out_rsp_o
);

  localparam int unsigned ADDR_W = MAX_QUBITS;
  localparam int unsigned DEPTH  = 1 << ADDR_W;
  localparam int unsigned PROB_W = ADDR_W + 32;

  logic [31:0] mem_q [DEPTH];
  logic [31:0] rdata_q, wdata_q, a0_q, a1_q, rd_q, mem_wd;
  logic        meas_q, sat_q, out_valid_q;
  logic [15:0] res_q [4];
  logic [PROB_W-1:0] prob_acc_q;
  out_rsp_t    out_rsp_q;

  // Multiplier pipeline stage
  logic signed [16:0] opa, opb;
  logic signed [33:0] prod_q;
  logic        pvalid_q, pneg_q, pfirst_q, plast_q, psh12_q, pprob_q;
  logic [1:0]  pdest_q;
  logic        neg_d, first_d, last_d, sh12_d, prob_d;
  logic [1:0]  dest_d;
  logic signed [35:0] acc_q, base, addend, sum, rnd, qv;
  logic [15:0] sat_val;
  logic        sat_hit, prob_ovf;

  // Request payload and captured pair amplitudes
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      wdata_q <= {in_req_i.write_real, in_req_i.write_imag};
      meas_q  <= in_req_i.measured_value;
    end
    if (cmd_i.cap_a0) a0_q <= rdata_q;
    if (cmd_i.cap_a1) a1_q <= rdata_q;
  end

  // Write data select
  always_comb begin
    mem_wd = '0;
    case (cmd_i.wsel)
      WS_REQ:   mem_wd = wdata_q;
      WS_CLEAR: mem_wd = (mem_addr_i == '0) ? ONE_AMP : '0;
      WS_PAIR_I: begin
        case (cmd_i.op)
          OP_GATE:       mem_wd = {res_q[0], res_q[1]};
          OP_LANE_RESET: mem_wd = a1_q;
          OP_COLLAPSE:   mem_wd = meas_q ? '0 : {res_q[0], res_q[1]};
          default:       mem_wd = '0;
        endcase
      end
      WS_PAIR_J: begin
        case (cmd_i.op)
          OP_GATE:     mem_wd = {res_q[2], res_q[3]};
          OP_COLLAPSE: mem_wd = meas_q ? {res_q[0], res_q[1]} : '0;
          default:     mem_wd = '0;
        endcase
      end
      default: mem_wd = '0;
    endcase
  end

  // Amplitude store, one port, registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_we) mem_q[mem_addr_i] <= mem_wd;
    if (cmd_i.mem_re) rdata_q <= mem_q[mem_addr_i];
  end

  // Operand select for the shared multiplier
  always_comb begin
    logic [31:0] av, mw;
    logic [15:0] x, y;
    av = a0_q; mw = cfg_i.matrix_00; x = '0; y = '0;
    opa = '0; opb = '0;
    neg_d = 1'b0; first_d = 1'b1; last_d = 1'b1; sh12_d = 1'b0; prob_d = 1'b0;
    dest_d = 2'd0;
    case (cmd_i.op)
      OP_GATE: begin
        av = cmd_i.mac_k[1] ? a1_q : a0_q;
        case ({cmd_i.mac_k[3], cmd_i.mac_k[1]})
          2'b00:   mw = cfg_i.matrix_00;
          2'b01:   mw = cfg_i.matrix_01;
          2'b10:   mw = cfg_i.matrix_10;
          default: mw = cfg_i.matrix_11;
        endcase
        case ({cmd_i.mac_k[2], cmd_i.mac_k[0]})
          2'b00:   begin x = mw[31:16]; y = av[31:16]; end
          2'b01:   begin x = mw[15:0];  y = av[15:0]; neg_d = 1'b1; end
          2'b10:   begin x = mw[31:16]; y = av[15:0]; end
          default: begin x = mw[15:0];  y = av[31:16]; end
        endcase
        opa     = {x[15], x};
        opb     = {y[15], y};
        dest_d  = cmd_i.mac_k[3:2];
        first_d = (cmd_i.mac_k[1:0] == 2'd0);
        last_d  = (cmd_i.mac_k[1:0] == 2'd3);
      end
      OP_COLLAPSE: begin
        av     = meas_q ? a1_q : a0_q;
        x      = cmd_i.mac_k[0] ? av[15:0] : av[31:16];
        opa    = {x[15], x};
        opb    = {1'b0, cfg_i.collapse_norm};
        dest_d = {1'b0, cmd_i.mac_k[0]};
        sh12_d = 1'b1;
      end
      OP_PROB: begin
        x      = cmd_i.mac_k[0] ? a0_q[15:0] : a0_q[31:16];
        opa    = {x[15], x};
        opb    = {x[15], x};
        prob_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pvalid_q <= 1'b0;
    end else begin
      pvalid_q <= cmd_i.mac_issue;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q   <= opa * opb;
    pneg_q   <= neg_d;
    pfirst_q <= first_d;
    plast_q  <= last_d;
    psh12_q  <= sh12_d;
    pprob_q  <= prob_d;
    pdest_q  <= dest_d;
  end

  // Accumulate, round half up, saturate
  always_comb begin
    base    = pfirst_q ? '0 : acc_q;
    addend  = {{2{prod_q[33]}}, prod_q};
    sum     = pneg_q ? (base - addend) : (base + addend);
    rnd     = sum + (psh12_q ? 36'sd2048 : 36'sd8192);
    qv      = psh12_q ? (rnd >>> 12) : (rnd >>> 14);
    sat_hit = 1'b0;
    if (qv > 36'sd32767) begin
      sat_val = 16'h7FFF; sat_hit = 1'b1;
    end else if (qv < -36'sd32768) begin
      sat_val = 16'h8000; sat_hit = 1'b1;
    end else begin
      sat_val = qv[15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pvalid_q && !pprob_q) begin
      acc_q <= sum;
      if (plast_q) res_q[pdest_q] <= sat_val;
    end
  end

  // Working flags and sums, cleared when a request is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sat_q      <= 1'b0;
      prob_acc_q <= '0;
      rd_q       <= '0;
    end else if (cmd_i.load) begin
      sat_q      <= 1'b0;
      prob_acc_q <= '0;
      rd_q       <= '0;
    end else begin
      if (pvalid_q && pprob_q) prob_acc_q <= prob_acc_q + PROB_W'($unsigned(prod_q));
      if (pvalid_q && !pprob_q && plast_q && sat_hit) sat_q <= 1'b1;
      if (cmd_i.cap_rd) rd_q <= rdata_q;
    end
  end

  assign prob_ovf = |prob_acc_q[PROB_W-1:32];

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_rsp_q.read_real   <= rd_q[31:16];
      out_rsp_q.read_imag   <= rd_q[15:0];
      out_rsp_q.probability <= prob_ovf ? 32'hFFFF_FFFF : prob_acc_q[31:0];
      out_rsp_q.saturated   <= sat_q | prob_ovf;
    end
  end

  assign status_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o       = out_valid_q;
  assign out_rsp_o         = out_rsp_q;

endmodule

### src/qsvge_ctrl.sv
module qsvge_ctrl import qsvge_pkg::*; #(
  parameter int unsigned MAX_QUBITS = 10
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cfg_t                  cfg_i,
  input  logic                  in_valid_i,
  input  in_req_t               in_req_i,
  output logic                  in_stall_o,
  input  dp_status_t            status_i,
  output dp_cmd_t               cmd_o,
  output logic [MAX_QUBITS-1:0] mem_addr_o
);

  localparam int unsigned ADDR_W = MAX_QUBITS;
  localparam logic [4:0]  MAX_N  = 5'(MAX_QUBITS);

  state_e state_q, state_d;
  op_e    op_q, op_d;
  logic [ADDR_W-1:0] addr_q, addr_d, pair_q, pair_d, clr_q, clr_d;
  logic [3:0]  k_q, k_d;
  logic        reply_q, reply_d;

  logic [4:0]  q_ext, n;
  logic [ADDR_W-1:0] size_m1, tbit, low_mask, pair_i, pair_j, mask_ext, addr_ext, cmask;
  logic        lane_ok, ctrl_ok, last_pair, accept;
  logic [3:0]  last_k;

  // Ten-bit request and mask fields mapped onto the store's index width
  for (genvar b = 0; b < ADDR_W; b++) begin : g_ext
    if (b < FIELD_ADDR_W) begin : g_in
      assign mask_ext[b] = cfg_i.control_mask[b];
      assign addr_ext[b] = in_req_i.address[b];
    end else begin : g_pad
      assign mask_ext[b] = 1'b0;
      assign addr_ext[b] = 1'b0;
    end
  end

  // Active size and pair addressing
  assign q_ext     = {1'b0, cfg_i.qubits_in_use};
  assign n         = (q_ext == 5'd0) ? 5'd1 : ((q_ext > MAX_N) ? MAX_N : q_ext);
  assign size_m1   = ~({ADDR_W{1'b1}} << n);
  assign lane_ok   = ({1'b0, cfg_i.target_lane} < n);
  assign tbit      = lane_ok ? (ADDR_W'(1) << cfg_i.target_lane) : '0;
  assign low_mask  = tbit - ADDR_W'(1);
  assign pair_i    = ((pair_q & ~low_mask) << 1) | (pair_q & low_mask);
  assign pair_j    = pair_i | tbit;
  assign cmask     = mask_ext & size_m1 & ~tbit;
  assign ctrl_ok   = ((pair_i & cmask) == cmask);
  assign last_pair = (pair_q == (size_m1 >> 1));
  assign last_k    = (op_q == OP_GATE) ? GATE_LAST_K : PAIR_LAST_K;
  assign accept    = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      op_q    <= OP_INIT;
      addr_q  <= '0;
      pair_q  <= '0;
      clr_q   <= '0;
      k_q     <= '0;
      reply_q <= 1'b0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      addr_q  <= addr_d;
      pair_q  <= pair_d;
      clr_q   <= clr_d;
      k_q     <= k_d;
      reply_q <= reply_d;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    addr_d     = addr_q;
    pair_d     = pair_q;
    clr_d      = clr_q;
    k_d        = k_q;
    reply_d    = reply_q;
    cmd_o      = '0;
    cmd_o.op   = op_q;
    cmd_o.wsel = WS_REQ;
    cmd_o.mac_k = k_q;
    mem_addr_o = addr_q;
    case (state_q)
      ST_CLEAR: begin
        mem_addr_o   = clr_q;
        cmd_o.mem_we = 1'b1;
        cmd_o.wsel   = WS_CLEAR;
        clr_d        = clr_q + ADDR_W'(1);
        if (clr_q == {ADDR_W{1'b1}}) state_d = reply_q ? ST_DONE : ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          op_d       = op_e'(in_req_i.opcode);
          addr_d     = addr_ext & size_m1;
          reply_d    = 1'b1;
          clr_d      = '0;
          pair_d     = '0;
          case (op_e'(in_req_i.opcode))
            OP_WRITE, OP_READ: state_d = ST_ACCESS;
            OP_INIT:           state_d = ST_CLEAR;
            OP_GATE, OP_LANE_RESET, OP_COLLAPSE, OP_PROB:
              state_d = lane_ok ? ST_RD_I : ST_DONE;
            default:           state_d = ST_DONE;
          endcase
        end
      end
      ST_ACCESS: begin
        if (op_q == OP_WRITE) begin
          cmd_o.mem_we = 1'b1;
          state_d      = ST_DONE;
        end else begin
          cmd_o.mem_re = 1'b1;
          state_d      = ST_CAP_RD;
        end
      end
      ST_CAP_RD: begin
        cmd_o.cap_rd = 1'b1;
        state_d      = ST_DONE;
      end
      ST_RD_I: begin
        mem_addr_o = pair_i;
        if (op_q == OP_GATE && !ctrl_ok) begin
          state_d = ST_NEXT;
        end else begin
          cmd_o.mem_re = 1'b1;
          state_d      = ST_RD_J;
        end
      end
      ST_RD_J: begin
        mem_addr_o   = pair_j;
        cmd_o.mem_re = 1'b1;
        cmd_o.cap_a0 = 1'b1;
        state_d      = ST_CAP;
      end
      ST_CAP: begin
        cmd_o.cap_a1 = 1'b1;
        k_d          = '0;
        state_d      = (op_q == OP_LANE_RESET) ? ST_WR_I : ST_MAC;
      end
      ST_MAC: begin
        cmd_o.mac_issue = 1'b1;
        k_d             = k_q + 4'd1;
        if (k_q == last_k) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_d = (op_q == OP_PROB) ? ST_NEXT : ST_WR_I;
      end
      ST_WR_I: begin
        mem_addr_o   = pair_i;
        cmd_o.mem_we = 1'b1;
        cmd_o.wsel   = WS_PAIR_I;
        state_d      = ST_WR_J;
      end
      ST_WR_J: begin
        mem_addr_o   = pair_j;
        cmd_o.mem_we = 1'b1;
        cmd_o.wsel   = WS_PAIR_J;
        state_d      = ST_NEXT;
      end
      ST_NEXT: begin
        if (last_pair) begin
          state_d = ST_DONE;
        end else begin
          pair_d  = pair_q + ADDR_W'(1);
          state_d = ST_RD_I;
        end
      end
      ST_DONE: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

### src/qubit_state_vector_gate_engine.sv
// State vector gate engine: 2^MAX_QUBITS complex amplitudes, Q1.14 real/imag.
// Request channel (in_valid_i / in_stall_o / in_req_i) takes one command at a
// time; every command returns one response on out_valid_o / out_stall_i /
// out_rsp_o. Configuration is a plain write port (cfg_we_i, cfg_index_i,
// cfg_wdata_i). The configuration must be written only while the engine is
// idle; the engine itself does not enforce this.
// A write or read touches one store word, and an unused opcode only returns
// a response; init clears all 2^MAX_QUBITS store words to the zero state
// (one store word per cycle). Gate, collapse, lane reset and probability
// walk the 2^(qubits_in_use-1) amplitude pairs of the target lane; a gate
// forms 16 products per pair through one 17x17 multiplier and skips the
// pairs that the control mask rules out.
// The single-port amplitude memory and the shared multiplier set the pace;
// one request is in flight at a time.
// After reset the engine clears the store to |0>, holding in_stall_o high,
// then takes requests.
// A finished response sits in the output register while the next request is
// taken; if the receiver stalls, a second response waits in the engine and
// requests are held off until the output register frees.
module qubit_state_vector_gate_engine import qsvge_pkg::*; #(
  parameter int unsigned MAX_QUBITS = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_req_t     in_req_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_rsp_t    out_rsp_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_wdata_i
);

  cfg_t       cfg_q;
  dp_cmd_t    cmd;
  dp_status_t status;
  logic [MAX_QUBITS-1:0] mem_addr;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_QUBITS:    cfg_q.qubits_in_use <= cfg_wdata_i[3:0];
        CFG_TARGET:    cfg_q.target_lane   <= cfg_wdata_i[3:0];
        CFG_CTRL_MASK: cfg_q.control_mask  <= cfg_wdata_i[9:0];
        CFG_M00:       cfg_q.matrix_00     <= cfg_wdata_i;
        CFG_M01:       cfg_q.matrix_01     <= cfg_wdata_i;
        CFG_M10:       cfg_q.matrix_10     <= cfg_wdata_i;
        CFG_M11:       cfg_q.matrix_11     <= cfg_wdata_i;
        CFG_NORM:      cfg_q.collapse_norm <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  qsvge_ctrl #(.MAX_QUBITS(MAX_QUBITS)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_req_i   (in_req_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd),
    .mem_addr_o (mem_addr)
  );

  qsvge_dp #(.MAX_QUBITS(MAX_QUBITS)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_req_i    (in_req_i),
    .cmd_i       (cmd),
    .mem_addr_i  (mem_addr),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule

### src/qsvge_checker.sv
`include "assert_macros.svh"

module qsvge_checker import qsvge_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input out_rsp_t out_rsp_o
);

  // Only a probability request gives a nonzero sum, and it reads nothing
  `QSV_ASSERT_IMPL(a_prob_no_read, clk_i, rst_ni, out_valid_o && (out_rsp_o.probability != 32'd0), (out_rsp_o.read_real == 16'sd0) && (out_rsp_o.read_imag == 16'sd0))
  // A read never clips
  `QSV_ASSERT_IMPL(a_sat_no_read, clk_i, rst_ni, out_valid_o && out_rsp_o.saturated, (out_rsp_o.read_real == 16'sd0) && (out_rsp_o.read_imag == 16'sd0))
  // Engine is busy the cycle after it takes a request
  `QSV_ASSERT_NEXT(a_busy_after_req, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)
  // No response appears in the cycle straight after a request
  `QSV_ASSERT_NEXT(a_no_instant_rsp, clk_i, rst_ni, in_valid_i && !in_stall_o, !$rose(out_valid_o))
  // Stalled response holds
  `QSV_ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_rsp_o))

endmodule

bind qubit_state_vector_gate_engine qsvge_checker u_qsvge_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_rsp_o   (out_rsp_o)
);

### dv/qubit_state_vector_gate_engine_tb.sv
module qubit_state_vector_gate_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import qsvge_pkg::*;

  localparam int unsigned LANES = 10;
  localparam int unsigned DEPTH = 1 << LANES;
  localparam int unsigned IDLE_LIMIT = 200000;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  in_req_t     in_req_i;
  logic        out_valid_o;
  logic        out_stall_i;
  out_rsp_t    out_rsp_o;
  logic        cfg_we_i;
  logic [2:0]  cfg_index_i;
  logic [31:0] cfg_wdata_i;

  qubit_state_vector_gate_engine #(.MAX_QUBITS(LANES)) u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_req_i,
    .out_valid_o, .out_stall_i, .out_rsp_o, .cfg_we_i, .cfg_index_i, .cfg_wdata_i
  );

  // Predictor state: amplitude copy and register shadow
  logic [31:0] amp_mirror [DEPTH];
  cfg_t        cfg_shadow;
  out_rsp_t    pending_rsp[$];
  int unsigned fail_count;
  int unsigned quiet_cycles;
  bit          idle_on;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic signed [15:0] round_clip(longint v, int sh, ref bit sat);
    longint q;
    v += longint'(1) <<< (sh - 1);
    q = v >>> sh;
    if (q > 32767) begin
      sat = 1'b1;
      return 16'sh7fff;
    end
    if (q < -32768) begin
      sat = 1'b1;
      return 16'sh8000;
    end
    return q[15:0];
  endfunction

  // m0*a0 + m1*a1, complex Q1.14
  function automatic logic [31:0] cmac(logic [31:0] m0, logic [31:0] a0,
                                       logic [31:0] m1, logic [31:0] a1, ref bit sat);
    longint m0r, m0i, m1r, m1i, a0r, a0i, a1r, a1i, re, im;
    m0r = $signed(m0[31:16]); m0i = $signed(m0[15:0]);
    m1r = $signed(m1[31:16]); m1i = $signed(m1[15:0]);
    a0r = $signed(a0[31:16]); a0i = $signed(a0[15:0]);
    a1r = $signed(a1[31:16]); a1i = $signed(a1[15:0]);
    re = m0r * a0r - m0i * a0i + m1r * a1r - m1i * a1i;
    im = m0r * a0i + m0i * a0r + m1r * a1i + m1i * a1r;
    return {round_clip(re, 14, sat), round_clip(im, 14, sat)};
  endfunction

  function automatic logic [31:0] norm_scale(logic [31:0] a, ref bit sat);
    longint n;
    n = cfg_shadow.collapse_norm;
    return {round_clip(longint'($signed(a[31:16])) * n, 12, sat),
            round_clip(longint'($signed(a[15:0])) * n, 12, sat)};
  endfunction

  function automatic void store_clear();
    foreach (amp_mirror[k]) amp_mirror[k] = '0;
    amp_mirror[0] = ONE_AMP;
  endfunction

  // Apply one request to the mirror and return its response
  function automatic out_rsp_t predict_state_vector(in_req_t rq);
    out_rsp_t    r;
    int unsigned n, sz, addr, tbit, cmask, j;
    bit          lane_ok, sat;
    longint      prob, re, im;
    logic [31:0] a0, a1;
    r = '0;
    sat = 1'b0;
    prob = 0;
    n = cfg_shadow.qubits_in_use;
    if (n < 1) n = 1;
    if (n > LANES) n = LANES;
    sz = 1 << n;
    addr = rq.address & (sz - 1);
    lane_ok = cfg_shadow.target_lane < n;
    tbit = lane_ok ? (1 << cfg_shadow.target_lane) : 0;
    cmask = cfg_shadow.control_mask & (sz - 1) & ~tbit;
    case (rq.opcode)
      OP_WRITE: amp_mirror[addr] = {rq.write_real, rq.write_imag};
      OP_READ:  {r.read_real, r.read_imag} = amp_mirror[addr];
      OP_INIT:  store_clear();
      OP_GATE, OP_LANE_RESET, OP_COLLAPSE, OP_PROB: begin
        if (lane_ok) begin
          for (int unsigned i = 0; i < sz; i++) begin
            if ((i & tbit) != 0) continue;
            j = i | tbit;
            a0 = amp_mirror[i];
            a1 = amp_mirror[j];
            if (rq.opcode == OP_GATE) begin
              if ((i & cmask) != cmask) continue;
              amp_mirror[i] = cmac(cfg_shadow.matrix_00, a0, cfg_shadow.matrix_01, a1, sat);
              amp_mirror[j] = cmac(cfg_shadow.matrix_10, a0, cfg_shadow.matrix_11, a1, sat);
            end else if (rq.opcode == OP_LANE_RESET) begin
              amp_mirror[i] = a1;
              amp_mirror[j] = '0;
            end else if (rq.opcode == OP_COLLAPSE) begin
              if (!rq.measured_value) begin
                amp_mirror[i] = norm_scale(a0, sat);
                amp_mirror[j] = '0;
              end else begin
                amp_mirror[i] = '0;
                amp_mirror[j] = norm_scale(a1, sat);
              end
            end else begin
              re = $signed(a0[31:16]);
              im = $signed(a0[15:0]);
              prob += re * re + im * im;
            end
          end
          if (prob > 64'hffff_ffff) begin
            prob = 64'hffff_ffff;
            sat = 1'b1;
          end
        end
      end
      default: ;
    endcase
    r.probability = prob[31:0];
    r.saturated = sat;
    return r;
  endfunction

  // Response checker with stall generation
  always @(posedge clk_i) begin
    out_rsp_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_rsp.size() == 0) begin
          $error("unexpected response %h", out_rsp_o);
          fail_count++;
        end else begin
          want = pending_rsp.pop_front();
          if (out_rsp_o.read_real !== want.read_real) begin
            $error("read_real exp %h got %h", want.read_real, out_rsp_o.read_real);
            fail_count++;
          end
          if (out_rsp_o.read_imag !== want.read_imag) begin
            $error("read_imag exp %h got %h", want.read_imag, out_rsp_o.read_imag);
            fail_count++;
          end
          if (out_rsp_o.probability !== want.probability) begin
            $error("probability exp %h got %h", want.probability, out_rsp_o.probability);
            fail_count++;
          end
          if (out_rsp_o.saturated !== want.saturated) begin
            $error("saturated exp %b got %b", want.saturated, out_rsp_o.saturated);
            fail_count++;
          end
        end
      end
      out_stall_i <= idle_on && ($urandom_range(99) < 37);
    end
  end

  // Watchdog on accepted traffic
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Valid stays high after the accept; the engine is busy on the next edge,
  // and the following request, an idle cycle or a drain takes it from there
  task automatic send_request(op_e op, logic [9:0] addr = '0, logic [31:0] amp = '0,
                              logic meas = 1'b0);
    in_req_t rq;
    while (idle_on && ($urandom_range(99) < 37)) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    rq.opcode = op;
    rq.address = addr;
    {rq.write_real, rq.write_imag} = amp;
    rq.measured_value = meas;
    in_valid_i <= 1'b1;
    in_req_i <= rq;
    do @(posedge clk_i); while (in_stall_o);
    pending_rsp = {pending_rsp, predict_state_vector(rq)};
  endtask

  // Wait for all responses then let the engine settle
  task automatic drain_requests();
    in_valid_i <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CFG_QUBITS:    cfg_shadow.qubits_in_use = val[3:0];
      CFG_TARGET:    cfg_shadow.target_lane = val[3:0];
      CFG_CTRL_MASK: cfg_shadow.control_mask = val[9:0];
      CFG_M00:       cfg_shadow.matrix_00 = val;
      CFG_M01:       cfg_shadow.matrix_01 = val;
      CFG_M10:       cfg_shadow.matrix_10 = val;
      CFG_M11:       cfg_shadow.matrix_11 = val;
      default:       cfg_shadow.collapse_norm = val[15:0];
    endcase
  endtask

  function automatic logic [31:0] rand_amp();
    case ($urandom_range(3))
      0:       return {16'h7fff, 16'h8000};
      1:       return {16'(($urandom_range(8192) - 4096)), 16'(($urandom_range(8192) - 4096))};
      default: return $urandom;
    endcase
  endfunction

  // Directed: extremes, every command, out-of-range lanes and wrap
  task automatic test_directed();
    write_reg(CFG_QUBITS, 2);
    send_request(OP_READ, 10'd0);
    send_request(OP_WRITE, 10'h3ff, {16'h7fff, 16'h8000});
    send_request(OP_READ, 10'd3);
    send_request(OP_WRITE, 10'd1, {16'h8000, 16'h7fff});
    send_request(OP_PROB);
    send_request(OP_GATE);
    send_request(OP_READ, 10'd1);
    send_request(op_e'(3'd7), 10'h3ff, '1, 1'b1);
    send_request(OP_COLLAPSE, 10'd0, '0, 1'b1);
    send_request(OP_LANE_RESET);
    send_request(OP_READ, 10'd0);
    send_request(OP_INIT);
    drain_requests();
    write_reg(CFG_TARGET, 15);
    send_request(OP_GATE);
    send_request(OP_PROB);
    send_request(OP_COLLAPSE);
    send_request(OP_LANE_RESET);
    drain_requests();
    write_reg(CFG_QUBITS, 0);
    write_reg(CFG_TARGET, 0);
    write_reg(CFG_NORM, 32'h0000_ffff);
    write_reg(CFG_M00, 32'h8000_8000);
    write_reg(CFG_M01, 32'h8000_8000);
    send_request(OP_WRITE, 10'd1, {16'h8000, 16'h8000});
    send_request(OP_GATE);
    send_request(OP_COLLAPSE);
    send_request(OP_READ, 10'd0);
    drain_requests();
  endtask

  // Random phases over several register settings
  task automatic test_random();
    op_e op;
    for (int ph = 0; ph < 12; ph++) begin
      idle_on = (ph != 5);
      write_reg(CFG_QUBITS, (ph == 11) ? 15 : ((ph % 4 == 3) ? 10 : $urandom_range(1, 4)));
      write_reg(CFG_TARGET, $urandom_range(10));
      write_reg(CFG_CTRL_MASK, (ph % 3 == 0) ? 0 : $urandom_range(1023));
      write_reg(CFG_M00, (ph % 2) ? $urandom : 32'h2d41_0000);
      write_reg(CFG_M01, (ph % 2) ? $urandom : 32'h2d41_0000);
      write_reg(CFG_M10, (ph % 2) ? $urandom : 32'h2d41_0000);
      write_reg(CFG_M11, (ph % 2) ? $urandom : 32'hd2bf_0000);
      write_reg(CFG_NORM, (ph == 4) ? 0 : $urandom_range(65535));
      for (int k = 0; k < ((ph % 4 == 3) ? 8 : 50); k++) begin
        op = op_e'($urandom_range(7));
        send_request(op, 10'($urandom), rand_amp(), 1'($urandom));
      end
      drain_requests();
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_req_i = '0;
    out_stall_i = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = CFG_QUBITS;
    cfg_wdata_i = '0;
    fail_count = 0;
    quiet_cycles = 0;
    idle_on = 1'b1;
    cfg_shadow = CFG_RESET;
    store_clear();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random();
    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
